FILE: src/rrmg_pkg.sv
// ---------------------------------------------------------------------------
// rrmg_pkg
// Shared types, constants and helpers for the request rate and motion guard.
// ---------------------------------------------------------------------------
package rrmg_pkg;

	localparam int TAG_SLOTS  = 256;
	localparam int TAG_W      = $clog2(TAG_SLOTS);
	localparam int MIN_WINDOW = 50;

	localparam int TIME_W  = 32;
	localparam int CNT_W   = 16;
	localparam int COORD_W = 24;
	localparam int LIM_W   = 23;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic [CNT_W-1:0] MIN_WINDOW_V = CNT_W'(MIN_WINDOW);

	localparam logic [CNT_W-1:0] RST_WINDOW  = 16'd1000;
	localparam logic [CNT_W-1:0] RST_MAX_REQ = 16'd10;
	localparam logic             RST_ENFORCE = 1'b1;

	typedef enum logic [2:0] {
		REG_WINDOW   = 3'd0,
		REG_MAX_REQ  = 3'd1,
		REG_ENFORCE  = 3'd2,
		REG_MAX_SPD  = 3'd3,
		REG_BOUND    = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		VERDICT_OK      = 2'd0,
		VERDICT_NO_AUTH = 2'd1,
		VERDICT_RATE    = 2'd2,
		VERDICT_MOTION  = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [TIME_W-1:0] start;
		logic [CNT_W-1:0]  count;
	} bucket_t;

	typedef struct packed {
		logic clr;
		logic mul_en;
		logic acc_en;
	} sq_ctrl_t;

	function automatic logic [COORD_W-1:0] mag(input logic [COORD_W-1:0] v);
		mag = v[COORD_W-1] ? (~v + COORD_W'(1)) : v;
	endfunction

endpackage

FILE: src/rrmg_bucket.sv
// ---------------------------------------------------------------------------
// rrmg_bucket
// Per-tag bucket store: window start and count, registered read, valid bits
// so that never-written entries read as zero after reset.
// ---------------------------------------------------------------------------
module rrmg_bucket
	import rrmg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [TAG_W-1:0] rd_addr,
	input  logic             wr_en,
	input  logic [TAG_W-1:0] wr_addr,
	input  bucket_t          wr_data,
	output bucket_t          rd_data
);

	bucket_t              mem_q [TAG_SLOTS];
	logic [TAG_SLOTS-1:0] valid_q;
	bucket_t              rd_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

FILE: src/rrmg_sq_unit.sv
// ---------------------------------------------------------------------------
// rrmg_sq_unit
// Shared squaring multiplier with registered product and sum-of-squares
// accumulator.
// ---------------------------------------------------------------------------
module rrmg_sq_unit
	import rrmg_pkg::*;
(
	input  logic               clk,
	input  sq_ctrl_t           ctrl,
	input  logic [COORD_W-1:0] operand,
	output logic [PROD_W-1:0]  prod,
	output logic [PROD_W-1:0]  acc
);

	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= PROD_W'(operand) * PROD_W'(operand);
		end
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + prod_q;
		end
	end

	assign prod = prod_q;
	assign acc  = acc_q;

endmodule

FILE: src/request_rate_and_motion_guard.sv
// ---------------------------------------------------------------------------
// request_rate_and_motion_guard
// Per-tag fixed-window rate limiter with owner speed and position checks.
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result shows
// on accepted/verdict/flagged for exactly one cycle with done high, and must
// be captured then since the receiver cannot stall it. A request that ends at
// the authority or rate check passes through ST_RATE only; one that runs the
// movement checks also steps through ST_SQ, where the single shared squaring
// multiplier computes vx^2, vy^2, vz^2 and max_speed^2 in turn.
// The bucket store needs no clearing pass after reset.
module request_rate_and_motion_guard
	import rrmg_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	input  logic                      start,
	output logic                      busy,
	input  logic [TAG_W-1:0]          tag,
	input  logic [TIME_W-1:0]         now_ticks,
	input  logic                      has_authority,
	input  logic                      owner_present,
	input  logic signed [COORD_W-1:0] vel_x,
	input  logic signed [COORD_W-1:0] vel_y,
	input  logic signed [COORD_W-1:0] vel_z,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] pos_z,
	output logic                      done,
	output logic                      accepted,
	output logic [1:0]                verdict,
	output logic                      flagged
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RATE = 3'b010,
		ST_SQ   = 3'b100
	} state_t;

	// configuration
	logic [CNT_W-1:0] window_q;
	logic [CNT_W-1:0] max_req_q;
	logic             enforce_q;
	logic [LIM_W-1:0] max_spd_q;
	logic [LIM_W-1:0] bound_q;
	reg_idx_t         reg_idx;
	logic             cfg_wr;

	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= RST_WINDOW;
			max_req_q <= RST_MAX_REQ;
			enforce_q <= RST_ENFORCE;
			max_spd_q <= '0;
			bound_q   <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_WINDOW:  window_q  <= pwdata[CNT_W-1:0];
				REG_MAX_REQ: max_req_q <= pwdata[CNT_W-1:0];
				REG_ENFORCE: enforce_q <= pwdata[0];
				REG_MAX_SPD: max_spd_q <= pwdata[LIM_W-1:0];
				REG_BOUND:   bound_q   <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WINDOW:  prdata = DATA_W'(window_q);
			REG_MAX_REQ: prdata = DATA_W'(max_req_q);
			REG_ENFORCE: prdata = DATA_W'(enforce_q);
			REG_MAX_SPD: prdata = DATA_W'(max_spd_q);
			REG_BOUND:   prdata = DATA_W'(bound_q);
			default:     prdata = '0;
		endcase
	end

	// request capture
	state_t             state_q;
	logic [2:0]         cnt_q;
	logic [TAG_W-1:0]   tag_q;
	logic [TIME_W-1:0]  now_q;
	logic               auth_q;
	logic               owner_q;
	logic [COORD_W-1:0] vx_q, vy_q, vz_q, px_q, py_q, pz_q;
	logic               take;

	assign busy = (state_q != ST_IDLE);
	assign take = start & ~busy;

	always_ff @(posedge clk) begin
		if (take) begin
			tag_q   <= tag;
			now_q   <= now_ticks;
			auth_q  <= has_authority;
			owner_q <= owner_present;
			vx_q    <= mag(vel_x);
			vy_q    <= mag(vel_y);
			vz_q    <= mag(vel_z);
			px_q    <= mag(pos_x);
			py_q    <= mag(pos_y);
			pz_q    <= mag(pos_z);
		end
	end

	// bucket check
	bucket_t          bkt_rd;
	bucket_t          bkt_wr;
	logic             bkt_we;
	logic [CNT_W-1:0] win;
	logic [CNT_W-1:0] limit;
	logic [TIME_W-1:0] elapsed;
	logic             fresh;
	logic [CNT_W-1:0] cur_cnt;
	logic             rate_bad;
	logic             motion_on;

	rrmg_bucket u_bucket (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (take),
		.rd_addr (tag),
		.wr_en   (bkt_we),
		.wr_addr (tag_q),
		.wr_data (bkt_wr),
		.rd_data (bkt_rd)
	);

	assign win       = (window_q < MIN_WINDOW_V) ? MIN_WINDOW_V : window_q;
	assign limit     = (max_req_q == '0) ? CNT_W'(1) : max_req_q;
	assign elapsed   = now_q - bkt_rd.start;
	assign fresh     = elapsed >= TIME_W'(win);
	assign cur_cnt   = fresh ? '0 : bkt_rd.count;
	assign rate_bad  = cur_cnt >= limit;
	assign motion_on = enforce_q & owner_q;

	assign bkt_we       = (state_q == ST_RATE) & auth_q & ~rate_bad;
	assign bkt_wr.start = fresh ? now_q : bkt_rd.start;
	assign bkt_wr.count = cur_cnt + CNT_W'(1);

	// movement check on the shared squaring unit
	sq_ctrl_t           sq_ctrl;
	logic [COORD_W-1:0] sq_op;
	logic [PROD_W-1:0]  sq_prod;
	logic [PROD_W-1:0]  sq_acc;
	logic               spd_bad;
	logic               pos_bad;

	always_comb begin
		case (cnt_q)
			3'd0:    sq_op = vx_q;
			3'd1:    sq_op = vy_q;
			3'd2:    sq_op = vz_q;
			default: sq_op = COORD_W'(max_spd_q);
		endcase
	end

	assign sq_ctrl.clr    = (state_q == ST_SQ) & (cnt_q == 3'd0);
	assign sq_ctrl.mul_en = (state_q == ST_SQ) & (cnt_q <= 3'd3);
	assign sq_ctrl.acc_en = (state_q == ST_SQ) & (cnt_q >= 3'd1) & (cnt_q <= 3'd3);

	rrmg_sq_unit u_sq (
		.clk     (clk),
		.ctrl    (sq_ctrl),
		.operand (sq_op),
		.prod    (sq_prod),
		.acc     (sq_acc)
	);

	assign spd_bad = (max_spd_q != '0) & (sq_acc > sq_prod);
	assign pos_bad = (bound_q != '0) &
		((px_q > COORD_W'(bound_q)) | (py_q > COORD_W'(bound_q)) |
		 (pz_q > COORD_W'(bound_q)));

	// sequencer and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			done     <= 1'b0;
			accepted <= 1'b0;
			verdict  <= VERDICT_OK;
			flagged  <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_RATE;
					end
				end
				ST_RATE: begin
					cnt_q <= '0;
					if (!auth_q) begin
						done     <= 1'b1;
						accepted <= 1'b0;
						verdict  <= VERDICT_NO_AUTH;
						flagged  <= 1'b0;
						state_q  <= ST_IDLE;
					end else if (rate_bad) begin
						done     <= 1'b1;
						accepted <= 1'b0;
						verdict  <= VERDICT_RATE;
						flagged  <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (!motion_on) begin
						done     <= 1'b1;
						accepted <= 1'b1;
						verdict  <= VERDICT_OK;
						flagged  <= 1'b0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) begin
						done    <= 1'b1;
						state_q <= ST_IDLE;
						if (spd_bad | pos_bad) begin
							accepted <= 1'b0;
							verdict  <= VERDICT_MOTION;
							flagged  <= 1'b1;
						end else begin
							accepted <= 1'b1;
							verdict  <= VERDICT_OK;
							flagged  <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
